// File: sv/pls_pkg.sv
// Shared types and constants for the positional list store.
`timescale 1ns / 1ps

package pls_pkg;

  localparam int unsigned POS_W  = 5;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_GET     = 3'd2,
    CMD_REPLACE = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  // Broadcast to every cell: what the accepted beat does and where.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             rep;
    logic [POS_W-1:0] tgt;
  } cell_ctrl_t;

endpackage

// File: sv/pls_cell.sv
// One slot of the list: holds an entry and trades it with its neighbours.
`timescale 1ns / 1ps

module pls_cell
  import pls_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [WIDTH-1:0] value,
  input  logic [WIDTH-1:0] lower,
  input  logic [WIDTH-1:0] upper,
  output logic [WIDTH-1:0] entry
);

  localparam logic [8:0] IdxW = 9'(IDX);

  logic [8:0]       tgt_w;
  logic             at_tgt;
  logic             above_tgt;
  logic [WIDTH-1:0] entry_next;

  assign tgt_w     = 9'(ctrl.tgt);
  assign at_tgt    = (tgt_w == IdxW);
  assign above_tgt = (IdxW > tgt_w);

  always_comb begin
    entry_next = entry;
    if (ctrl.ins) begin
      if (at_tgt) entry_next = value;
      else if (above_tgt) entry_next = lower;
    end else if (ctrl.rem) begin
      if (at_tgt || above_tgt) entry_next = upper;
    end else if (ctrl.rep && at_tgt) begin
      entry_next = value;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: sv/positional_list_store_core.sv
// Top level of the positional list store: command decode, count and result register.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------
//   in      | in_valid / in_stall   | cmd, position, value
//   out     | out_valid / out_stall | ok, data, length, empty_res
//
// Every cell shifts, loads or holds at the clock edge that ends the cycle of acceptance.
// Results land in a single output register, so a new beat is taken while the
// previous result is being drained; in_stall is high only while that register is
// full and out_stall holds it. Reset empties the list; entry contents are not cleared.
`timescale 1ns / 1ps

module positional_list_store_core
  import pls_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [POS_W-1:0]  position,
  input  logic [DATA_W-1:0] value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              ok,
  output logic [DATA_W-1:0] data,
  output logic [POS_W-1:0]  length,
  output logic              empty_res
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic             accept;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic             in_list;
  logic             ins_fit;
  logic             ok_next;
  logic [DATA_W-1:0] data_next;
  logic [POS_W-1:0] tgt;
  cell_ctrl_t       ctrl;

  logic [WIDTH-1:0] value_w;
  logic [WIDTH-1:0] entries [DEPTH];
  logic [IDX_W-1:0] rd_idx;
  logic [WIDTH-1:0] rd_word;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign value_w  = WIDTH'(value);

  assign pos_c   = CMP_W'(position);
  assign cnt_c   = CMP_W'(count);
  assign in_list = (position != '0) && (pos_c <= cnt_c);
  assign ins_fit = (position != '0) && (pos_c <= cnt_c + CMP_W'(1))
                   && (cnt_c < CMP_W'(DEPTH));

  assign tgt     = position - POS_W'(1);
  assign rd_idx  = IDX_W'(tgt);
  assign rd_word = entries[rd_idx];

  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.rem   = 1'b0;
    ctrl.rep   = 1'b0;
    ctrl.tgt   = tgt;
    ok_next    = 1'b0;
    data_next  = '0;
    count_next = count;
    case (cmd)
      CMD_INSERT: begin
        ok_next = ins_fit;
        if (ins_fit) begin
          ctrl.ins   = accept;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        ok_next = in_list;
        if (in_list) begin
          ctrl.rem   = accept;
          count_next = count - CNT_W'(1);
        end
      end
      CMD_GET: begin
        ok_next = in_list;
        if (in_list) data_next = DATA_W'(rd_word);
      end
      CMD_REPLACE: begin
        ok_next = in_list;
        if (in_list) begin
          ctrl.rep  = accept;
          data_next = DATA_W'(rd_word);
        end
      end
      CMD_CLEAR: begin
        ok_next    = 1'b1;
        count_next = '0;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // Row of cells; the top cell's upper neighbour folds back on itself, the bottom cell's lower one is the input value.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] lower;
    logic [WIDTH-1:0] upper;
    if (i == 0) begin : g_lo_end
      assign lower = value_w;
    end else begin : g_lo
      assign lower = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi_end
      assign upper = entries[i];
    end else begin : g_hi
      assign upper = entries[i+1];
    end
    pls_cell #(
      .IDX   (i),
      .WIDTH (WIDTH)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .value (value_w),
      .lower (lower),
      .upper (upper),
      .entry (entries[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok        <= ok_next;
      data      <= data_next;
      length    <= POS_W'(count_next);
      empty_res <= (count_next == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("list length beyond capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_CLEAR) |=> out_valid && ok && empty_res && (count == '0))
    else $error("clear did not empty the list");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (rst)
    accept && !ok_next |=> $stable(count))
    else $error("rejected beat changed the length");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

endmodule

// File: dv/tb_positional_list_store_core.sv
// Self-checking testbench for the positional list store core.
`timescale 1ns / 1ps

import pls_pkg::*;

typedef struct packed {
  logic              ok;
  logic [DATA_W-1:0] data;
  logic [POS_W-1:0]  length;
  logic              empty;
} list_result_t;

// Shadow copy of the list; predicts each result and matches it against the block.
class list_mirror #(int unsigned CAPACITY = 16);
  logic [DATA_W-1:0] cells[CAPACITY];
  int unsigned       fill;
  list_result_t      expected_results[$];
  int unsigned       mismatches;

  function new();
    fill       = 0;
    mismatches = 0;
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction

  function void note_command(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
                             logic [DATA_W-1:0] v);
    list_result_t r;
    logic         in_list;
    int           i;
    r.ok    = 1'b0;
    r.data  = '0;
    in_list = (p >= 1) && (p <= fill);
    case (c)
      CMD_INSERT: begin
        if (p >= 1 && p <= fill + 1 && fill < CAPACITY) begin
          for (i = fill; i >= p; i--) cells[i] = cells[i-1];
          cells[p-1] = v;
          fill++;
          r.ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (in_list) begin
          for (i = p; i < fill; i++) cells[i-1] = cells[i];
          fill--;
          r.ok = 1'b1;
        end
      end
      CMD_GET: begin
        if (in_list) begin
          r.data = cells[p-1];
          r.ok   = 1'b1;
        end
      end
      CMD_REPLACE: begin
        if (in_list) begin
          r.data     = cells[p-1];
          cells[p-1] = v;
          r.ok       = 1'b1;
        end
      end
      CMD_CLEAR: begin
        fill = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.length = fill[POS_W-1:0];
    r.empty  = (fill == 0);
    expected_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [DATA_W-1:0] exp_v,
                              logic [DATA_W-1:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endfunction

  function void check_result(list_result_t got);
    list_result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result beat: expected none, actual %0h", $time, got);
      return;
    end
    want = expected_results.pop_front();
    compare_field("ok", DATA_W'(want.ok), DATA_W'(got.ok));
    compare_field("data", want.data, got.data);
    compare_field("length", DATA_W'(want.length), DATA_W'(got.length));
    compare_field("empty_res", DATA_W'(want.empty), DATA_W'(got.empty));
  endfunction
endclass

module tb_positional_list_store_core;

  localparam int unsigned LIST_DEPTH = 16;
  localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_BEATS = 96;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [CMD_W-1:0]  cmd;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] value;
  logic              out_valid;
  logic              out_stall;
  logic              ok;
  logic [DATA_W-1:0] data;
  logic [POS_W-1:0]  length;
  logic              empty_res;

  logic send_idle_en;
  logic recv_idle_en;

  list_mirror #(LIST_DEPTH) board;

  positional_list_store_core #(.DEPTH(LIST_DEPTH), .WIDTH(DATA_W)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .data      (data),
    .length    (length),
    .empty_res (empty_res)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  // Entered at a rising edge; returns at the edge where the beat was taken.
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                           input logic [DATA_W-1:0] v);
    int unsigned gap;
    gap = send_idle_en ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd      <= c;
    position <= p;
    value    <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_command(c, p, v);
  endtask

  // Hold off the sender until the last result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  function automatic logic [CMD_W-1:0] pick_cmd(mix_t m);
    int unsigned r;
    int unsigned t_ins;
    int unsigned t_rem;
    int unsigned t_get;
    int unsigned t_rep;
    r = $urandom_range(0, 99);
    case (m)
      MIX_GROW:   begin t_ins = 55; t_rem = 65; t_get = 80; t_rep = 98; end
      MIX_SHRINK: begin t_ins = 15; t_rem = 70; t_get = 85; t_rep = 99; end
      default:    begin t_ins = 30; t_rem = 55; t_get = 75; t_rep = 97; end
    endcase
    if (r < t_ins) return CMD_INSERT;
    if (r < t_rem) return CMD_REMOVE;
    if (r < t_get) return CMD_GET;
    if (r < t_rep) return CMD_REPLACE;
    return CMD_CLEAR;
  endfunction

  task automatic random_beat(mix_t m);
    logic [CMD_W-1:0]  c;
    logic [POS_W-1:0]  p;
    logic [DATA_W-1:0] v;
    int unsigned       vsel;
    vsel = $urandom_range(0, 9);
    v    = (vsel == 0) ? '0 : (vsel == 1) ? '1 : $urandom;
    if ($urandom_range(0, 99) < 8) begin
      // noise: any code, any position
      c = CMD_W'($urandom_range(0, 7));
      p = POS_W'($urandom_range(0, 31));
    end else begin
      c = pick_cmd(m);
      if (c == CMD_INSERT)
        p = POS_W'($urandom_range(1, board.fill + 1));
      else if (board.fill == 0)
        p = POS_W'($urandom_range(0, 1));
      else
        p = POS_W'($urandom_range(1, board.fill));
    end
    send_item(c, p, v);
  endtask

  // Result side: after each taken beat, stall for a drawn number of cycles.
  initial begin
    int unsigned  hold;
    list_result_t got;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.ok    = ok;
        got.data  = data;
        got.length = length;
        got.empty = empty_res;
        board.check_result(got);
        hold = recv_idle_en ? $urandom_range(0, 19) : 0;
        if (hold > 0) out_stall <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        if (hold == 0) out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned ph;
    int unsigned n;
    mix_t        m;
    board        = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd          = '0;
    position     = '0;
    value        = '0;
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty list: every access is out of range
    send_item(CMD_GET, 5'd1, '0);
    send_item(CMD_REMOVE, 5'd1, '0);
    send_item(CMD_REPLACE, 5'd0, 32'h1234_5678);
    send_item(CMD_INSERT, 5'd0, 32'hDEAD_BEEF);
    send_item(CMD_INSERT, 5'd2, 32'hDEAD_BEEF);
    // front, tail and middle inserts
    send_item(CMD_INSERT, 5'd1, 32'h0000_0000);
    send_item(CMD_INSERT, 5'd2, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 5'd1, 32'hA5A5_A5A5);
    send_item(CMD_INSERT, 5'd2, 32'h5A5A_5A5A);
    send_item(CMD_GET, 5'd1, '0);
    send_item(CMD_GET, 5'd4, '0);
    send_item(CMD_GET, 5'd5, '0);
    send_item(CMD_REPLACE, 5'd2, 32'hFFFF_FFFF);
    send_item(CMD_REMOVE, 5'd1, '0);
    send_item(CMD_REMOVE, 5'd3, '0);
    send_item(CMD_REMOVE, 5'd2, '0);
    send_item(CMD_RSVD_5, 5'd1, 32'hFFFF_FFFF);
    send_item(CMD_RSVD_6, 5'd1, '0);
    send_item(CMD_RSVD_7, 5'd31, '0);
    send_item(CMD_CLEAR, 5'd0, '0);
    // fill to capacity, then push against the limit
    for (n = 0; n < LIST_DEPTH; n++)
      send_item(CMD_INSERT, POS_W'($urandom_range(1, board.fill + 1)), $urandom);
    send_item(CMD_INSERT, 5'd17, 32'h0BAD_F00D);
    send_item(CMD_INSERT, 5'd5, 32'h0BAD_F00D);
    send_item(CMD_GET, 5'd16, '0);
    send_item(CMD_GET, 5'd31, '0);
    send_item(CMD_REMOVE, 5'd16, '0);
    send_item(CMD_CLEAR, 5'd3, '0);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      send_idle_en = ($urandom_range(0, 3) != 0);
      recv_idle_en = ($urandom_range(0, 3) != 0);
      case (ph % 3)
        0:       m = MIX_GROW;
        1:       m = MIX_SHRINK;
        default: m = MIX_BALANCED;
      endcase
      for (n = 0; n < PHASE_BEATS; n++) random_beat(m);
      if (ph % 4 == 3) drain();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
sv/pls_pkg.sv
sv/pls_cell.sv
sv/positional_list_store_core.sv
dv/tb_positional_list_store_core.sv
